// ===== design/pru_pkg.sv =====
package pru_pkg;

  // Input opcodes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_SCALE_FACTOR = 1'b0;
  localparam logic CFG_ROW_WIDTH    = 1'b1;

  localparam int CFG_DATA_W = 11;

  // Work handed from the front part to the back part: one pixel to be copied, or a dropped push.
  typedef struct packed {
    logic        drop;
    logic        at_end;
    logic [23:0] pixel;   // red, green, blue from high byte to low byte
  } job_t;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_DROP,
    KIND_REPLAY
  } kind_t;

endpackage

// ===== design/pru_if.sv =====
interface pru_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, output op, output blue, output green, output red,
                  input ready);
  modport sink   (input valid, input op, input blue, input green, input red,
                  output ready);
endinterface

interface pru_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic       row_end;
  logic [1:0] pad_bytes;
  logic       last;
  logic       dropped;

  modport source (output valid, output out_blue, output out_green, output out_red,
                  output row_end, output pad_bytes, output last, output dropped,
                  input ready);
  modport sink   (input valid, input out_blue, input out_green, input out_red,
                  input row_end, input pad_bytes, input last, input dropped,
                  output ready);
endinterface

// ===== design/pru_front.sv =====
module pru_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 16,
  parameter int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  parameter int SW = $clog2(MAX_SCALE + 1)
) (
  input  logic           clk,
  input  logic           rst,
  pru_in_if.sink         pix_in,
  input  logic [SW-1:0]  eff_scale,
  input  logic [IW-1:0]  last_pos,
  output logic           job_valid,
  input  logic           job_ready,
  output pru_pkg::job_t  job
);

  logic [IW-1:0] write_index;
  logic [IW-1:0] replay_index;
  logic [SW-1:0] replay_rows_left;

  logic [23:0] line_store [MAX_WIDTH];
  logic [23:0] rd_data;

  logic          s1_valid;
  pru_pkg::kind_t s1_kind;
  logic          s1_at_end;
  logic [23:0]   s1_pixel;

  logic           accept;
  logic           is_push;
  logic           pending;
  logic [IW-1:0]  idx_raw;
  logic [IW-1:0]  idx;
  logic           at_end;
  logic           mem_we;
  logic           mem_re;
  logic           issue;
  pru_pkg::kind_t kind;
  logic [23:0]    in_pixel;

  assign pix_in.ready = !s1_valid || job_ready;
  assign accept       = pix_in.valid && pix_in.ready;
  assign is_push      = (pix_in.op == pru_pkg::OP_PUSH);
  assign pending      = (replay_rows_left != '0);
  assign in_pixel     = {pix_in.red, pix_in.green, pix_in.blue};

  // A position at or beyond the last one counts as the row end.
  assign idx_raw = is_push ? write_index : replay_index;
  assign at_end  = (idx_raw >= last_pos);
  assign idx     = at_end ? last_pos : idx_raw;

  always_comb begin
    kind  = pru_pkg::KIND_PIXEL;
    issue = 1'b0;
    if (is_push) begin
      issue = 1'b1;
      kind  = pending ? pru_pkg::KIND_DROP : pru_pkg::KIND_PIXEL;
    end else begin
      issue = pending;
      kind  = pru_pkg::KIND_REPLAY;
    end
  end

  assign mem_we = accept && (kind == pru_pkg::KIND_PIXEL) && issue;
  assign mem_re = accept && (kind == pru_pkg::KIND_REPLAY) && issue;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[idx] <= in_pixel;
    end
    if (mem_re) begin
      rd_data <= line_store[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index      <= '0;
      replay_index     <= '0;
      replay_rows_left <= '0;
    end else if (accept && issue) begin
      case (kind)
        pru_pkg::KIND_PIXEL: begin
          if (at_end) begin
            write_index      <= '0;
            replay_index     <= '0;
            replay_rows_left <= eff_scale - 1'b1;
          end else begin
            write_index <= idx + 1'b1;
          end
        end
        pru_pkg::KIND_REPLAY: begin
          if (at_end) begin
            replay_index     <= '0;
            replay_rows_left <= replay_rows_left - 1'b1;
          end else begin
            replay_index <= idx + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_in.ready) begin
      s1_valid <= accept && issue;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind   <= kind;
      s1_at_end <= at_end && (kind != pru_pkg::KIND_DROP);
      s1_pixel  <= (kind == pru_pkg::KIND_DROP) ? 24'h000000 : in_pixel;
    end
  end

  assign job_valid  = s1_valid;
  assign job.drop   = (s1_kind == pru_pkg::KIND_DROP);
  assign job.at_end = s1_at_end;
  assign job.pixel  = (s1_kind == pru_pkg::KIND_REPLAY) ? rd_data : s1_pixel;

endmodule

// ===== design/pru_queue.sv =====
module pru_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  pru_pkg::job_t wr_job,
  output logic          rd_valid,
  input  logic          rd_ready,
  output pru_pkg::job_t rd_job
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  pru_pkg::job_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          push;
  logic          pop;

  assign wr_ready = (count < (PW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/pru_back.sv =====
module pru_back #(
  parameter int MAX_SCALE = 16,
  parameter int SW = $clog2(MAX_SCALE + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [SW-1:0] eff_scale,
  input  logic [1:0]    pad,
  input  logic          job_valid,
  output logic          job_ready,
  input  pru_pkg::job_t job,
  pru_out_if.source     pix_out
);

  logic [SW-1:0] copy;
  logic          fin;
  logic          load;
  logic          row_end;

  assign fin       = job.drop || (copy == eff_scale - 1'b1);
  assign load      = job_valid && (!pix_out.valid || pix_out.ready);
  assign job_ready = load && fin;
  assign row_end   = fin && job.at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      copy          <= '0;
      pix_out.valid <= 1'b0;
    end else begin
      if (load) begin
        copy <= fin ? '0 : copy + 1'b1;
      end
      if (load) begin
        pix_out.valid <= 1'b1;
      end else if (pix_out.ready) begin
        pix_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_out.out_blue  <= job.pixel[7:0];
      pix_out.out_green <= job.pixel[15:8];
      pix_out.out_red   <= job.pixel[23:16];
      pix_out.row_end   <= row_end;
      pix_out.pad_bytes <= row_end ? pad : 2'd0;
      pix_out.last      <= fin;
      pix_out.dropped   <= job.drop;
    end
  end

endmodule

// ===== design/pixel_replicating_upscaler_unit.sv =====
// Nearest-neighbour integer upscaler for 24-bit pixels in BMP row order. A pushed
// pixel is stored in the line buffer and sent out scale_factor times; the last
// pixel of a source row arms scale_factor-1 replay rows, and each tick then
// replays one buffered pixel scale_factor times. Every pushed or replayed pixel
// is turned into scale_factor output words, at one word per cycle while the
// output is not stalled, and a dropped push into a single flagged word; an idle
// tick makes no word. The copy counter in the back part counts the copies. The
// first word of an item passes the front stage register, which also holds the
// line buffer read, then the queue, after which the output register loads it.
// The line buffer needs no clearing after reset.
module pixel_replicating_upscaler_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [pru_pkg::CFG_DATA_W-1:0] cfg_data,
  pru_in_if.sink                        pix_in,
  pru_out_if.source                     pix_out
);

  localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SW = $clog2(MAX_SCALE + 1);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [4:0]  scale_factor;
  logic [10:0] row_width;

  logic [SW-1:0] eff_scale;
  logic [WW-1:0] eff_width;
  logic [IW-1:0] last_pos;
  logic [1:0]    pad;

  logic          fq_valid;
  logic          fq_ready;
  pru_pkg::job_t fq_job;
  logic          qb_valid;
  logic          qb_ready;
  pru_pkg::job_t qb_job;

  // Configuration registers. They are written only while the block is idle; the user ensures this, unchecked.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= 5'd1;
      row_width    <= 11'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        pru_pkg::CFG_SCALE_FACTOR: scale_factor <= cfg_data[4:0];
        pru_pkg::CFG_ROW_WIDTH:    row_width    <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  // A zero setting acts as one, and a setting above the supported maximum
  // saturates to that maximum.
  always_comb begin
    if (scale_factor == 5'd0) begin
      eff_scale = SW'(1);
    end else if (32'(scale_factor) > 32'(MAX_SCALE)) begin
      eff_scale = SW'(MAX_SCALE);
    end else begin
      eff_scale = SW'(scale_factor);
    end
    if (row_width == 11'd0) begin
      eff_width = WW'(1);
    end else if (32'(row_width) > 32'(MAX_WIDTH)) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(row_width);
    end
  end

  assign last_pos = IW'(eff_width - 1'b1);

  // The row padding (4 - 3*n*w mod 4) mod 4 reduces to n*w mod 4, which only
  // needs the two low bits of each factor.
  assign pad = 2'(2'(eff_scale) * 2'(eff_width));

  pru_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE),
    .IW        (IW),
    .SW        (SW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in),
    .eff_scale (eff_scale),
    .last_pos  (last_pos),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  // A short queue lets the front keep accepting while the back is still
  // sending copies of an earlier pixel.
  pru_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_job   (fq_job),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_job   (qb_job)
  );

  pru_back #(
    .MAX_SCALE (MAX_SCALE),
    .SW        (SW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .eff_scale (eff_scale),
    .pad       (pad),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .pix_out   (pix_out)
  );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Sizes of the block as it is built here (its parameter defaults).
  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned MAX_SCALE = 16;

  // Rough number of random items that reach the block and cause output.
  localparam int unsigned RANDOM_ITEMS = 200;

  // A phase with this step budget only ends when its row and replay are done.
  localparam int unsigned NO_LIMIT = 100000;

  // Length of the one long stall on the output side, in cycles.
  localparam int unsigned LONG_HOLD = 400;

  // Cycles to let pass once every expected word is in: a margin for an idle
  // tick still on its way through the block.
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef logic [pru_pkg::CFG_DATA_W-1:0] cfg_word_t;

  // One output word as it is compared: every field of the result channel.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       last;
    logic       dropped;
  } pixel_word_t;

  // Mirror of the upscaler: it keeps its own registers, line buffer and
  // replay counters, turns every accepted input word into the output words
  // it must cause, and checks the words that come out against them in order.
  class upscale_scoreboard;
    bit [4:0]    scale_reg;
    bit [10:0]   width_reg;
    bit [23:0]   line_store [MAX_WIDTH];
    bit [9:0]    write_idx;
    bit [9:0]    replay_idx;
    bit [3:0]    rows_left;
    int unsigned filled;
    int unsigned mismatches;
    pixel_word_t pending_words [$];

    function new();
      scale_reg  = 5'd1;
      width_reg  = 11'd1;
      write_idx  = '0;
      replay_idx = '0;
      rows_left  = '0;
      filled     = 0;
      mismatches = 0;
    endfunction

    function int unsigned scale_of(bit [4:0] v);
      if (v == 5'd0) return 1;
      if (32'(v) > MAX_SCALE) return MAX_SCALE;
      return 32'(v);
    endfunction

    function int unsigned width_of(bit [10:0] v);
      if (v == 11'd0) return 1;
      if (32'(v) > MAX_WIDTH) return MAX_WIDTH;
      return 32'(v);
    endfunction

    function void write_reg(logic idx, cfg_word_t val);
      if (idx == pru_pkg::CFG_SCALE_FACTOR) scale_reg = val[4:0];
      else width_reg = val;
    endfunction

    function bit replay_pending();
      return rows_left != 0;
    endfunction

    function bit at_row_start();
      return rows_left == 0 && write_idx == 0;
    endfunction

    // With replay pending, a wider row would read entries never written.
    function bit width_is_safe(bit [10:0] v);
      return rows_left == 0 || width_of(v) <= filled;
    endfunction

    function int unsigned outstanding();
      return pending_words.size();
    endfunction

    function void queue_copies(bit [23:0] pix, int unsigned s, bit at_end,
                               int unsigned pad);
      pixel_word_t w;
      for (int unsigned k = 0; k < s; k++) begin
        w.blue      = pix[7:0];
        w.green     = pix[15:8];
        w.red       = pix[23:16];
        w.last      = (k + 1 == s);
        w.row_end   = w.last && at_end;
        w.pad_bytes = w.row_end ? 2'(pad) : 2'd0;
        w.dropped   = 1'b0;
        pending_words.push_back(w);
      end
    endfunction

    function void note_input(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
      int unsigned s;
      int unsigned w;
      int unsigned pad;
      int unsigned idx;
      bit          at_end;
      pixel_word_t drop_word;
      s   = scale_of(scale_reg);
      w   = width_of(width_reg);
      pad = (4 - (3 * s * w) % 4) % 4;
      if (op == pru_pkg::OP_PUSH) begin
        if (rows_left != 0) begin
          drop_word         = '0;
          drop_word.last    = 1'b1;
          drop_word.dropped = 1'b1;
          pending_words.push_back(drop_word);
          return;
        end
        idx = (32'(write_idx) >= w) ? w - 1 : 32'(write_idx);
        line_store[10'(idx)] = {r, g, b};
        if (idx + 1 > filled) filled = idx + 1;
        at_end = (idx >= w - 1);
        queue_copies({r, g, b}, s, at_end, pad);
        if (at_end) begin
          write_idx  = '0;
          rows_left  = 4'(s - 1);
          replay_idx = '0;
        end else begin
          write_idx = 10'(idx + 1);
        end
      end else if (rows_left != 0) begin
        idx = (32'(replay_idx) >= w) ? w - 1 : 32'(replay_idx);
        at_end = (idx >= w - 1);
        queue_copies(line_store[10'(idx)], s, at_end, pad);
        if (at_end) begin
          replay_idx = '0;
          rows_left  = rows_left - 4'd1;
        end else begin
          replay_idx = 10'(idx + 1);
        end
      end
    endfunction

    function string describe(pixel_word_t w);
      return $sformatf("b=%02h g=%02h r=%02h row_end=%b pad=%0d last=%b dropped=%b",
                       w.blue, w.green, w.red, w.row_end, w.pad_bytes, w.last,
                       w.dropped);
    endfunction

    function void check_word(pixel_word_t got);
      pixel_word_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word: %s", describe(got));
        return;
      end
      want = pending_words.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output word mismatch: expected %s, got %s", describe(want),
                   describe(got));
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we;
  logic      cfg_addr;
  cfg_word_t cfg_data;

  pru_in_if  in_ch ();
  pru_out_if out_ch ();

  upscale_scoreboard sb;

  // Per-phase switches: an eager side never idles, so that some stretches run
  // at full rate on that side.
  bit          tx_eager;
  bit          rx_eager;
  // Set by the stimulus to ask the output side for one long stall.
  bit          long_hold_req;
  int unsigned random_items;

  pixel_replicating_upscaler_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .pix_in   (in_ch),
    .pix_out  (out_ch)
  );

  always #10 clk = ~clk;

  // Guard against a hung handshake. The slowest legal run (every item making
  // sixteen words, every word waiting out the longest stall) stays well below.
  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned draw_gap(bit eager);
    return eager ? 0 : $urandom_range(0, 8);
  endfunction

  // Output side. Every word is sampled at the clock edge that accepts it, so
  // the values seen are the ones the block held going into that edge. After
  // each accepted word the receiver draws how long it will keep ready low;
  // the long stall, when asked for, is counted down here too, while the
  // sender keeps offering items and the block backs up onto its input.
  initial begin : drain_outputs
    int unsigned hold;
    pixel_word_t got;
    out_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_ch.valid && out_ch.ready) begin
          got = {out_ch.out_blue, out_ch.out_green, out_ch.out_red, out_ch.row_end,
                 out_ch.pad_bytes, out_ch.last, out_ch.dropped};
          sb.check_word(got);
          if (long_hold_req) begin
            hold = LONG_HOLD;
            long_hold_req = 1'b0;
          end else begin
            hold = draw_gap(rx_eager);
          end
        end
        if (hold != 0) begin
          hold--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Offers one input word after a drawn gap and returns at the edge that
  // accepts it. Valid is left high on return, so that a following word with no
  // gap goes straight on without valid being dropped and raised in one step.
  task automatic send_item(input logic op, input logic [7:0] b, input logic [7:0] g,
                           input logic [7:0] r);
    int unsigned gap;
    gap = draw_gap(tx_eager);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.blue  <= b;
    in_ch.green <= g;
    in_ch.red   <= r;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(op, b, g, r);
  endtask

  // Stops offering input and waits until every expected word has come out,
  // then waits out the settle margin in case an idle tick is still inside the block.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the scale register, then the width register, with the block idle.
  task automatic program_regs(input cfg_word_t scale_val, input cfg_word_t width_val);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_addr <= pru_pkg::CFG_SCALE_FACTOR;
    cfg_data <= scale_val;
    @(posedge clk);
    sb.write_reg(pru_pkg::CFG_SCALE_FACTOR, scale_val);
    cfg_addr <= pru_pkg::CFG_ROW_WIDTH;
    cfg_data <= width_val;
    @(posedge clk);
    sb.write_reg(pru_pkg::CFG_ROW_WIDTH, width_val);
    cfg_we <= 1'b0;
  endtask

  // Drives a well-formed stream from wherever the block stands: pushes while
  // a row is being filled, ticks while replay rows are pending. About one word
  // in ten is noise: an idle tick between rows, or a push that arrives during
  // replay and must come back flagged as dropped. The phase ends once a row
  // and all its replay rows are through, or early when the step budget runs
  // out, which leaves the block mid-row or mid-replay for the next settings.
  task automatic run_phase(input int unsigned max_steps);
    int unsigned steps;
    bit          moved;
    logic        op;
    steps = 0;
    moved = 1'b0;
    do begin
      if (sb.replay_pending())
        op = ($urandom_range(0, 9) == 0) ? pru_pkg::OP_PUSH : pru_pkg::OP_TICK;
      else
        op = ($urandom_range(0, 9) == 0) ? pru_pkg::OP_TICK : pru_pkg::OP_PUSH;
      if (op == pru_pkg::OP_PUSH || sb.replay_pending()) random_items++;
      if (op == pru_pkg::OP_PUSH) moved = 1'b1;
      send_item(op, 8'($urandom), 8'($urandom), 8'($urandom));
      steps++;
    end while (steps < max_steps && !(moved && sb.at_row_start()));
  endtask

  // Mostly small scales and short rows keep the replay cheap; now and then a
  // scale of zero, of sixteen or beyond (with junk in the unused data bits),
  // a width of zero or a longer row. A width that would make the pending
  // replay read unwritten entries is cut back to what has been filled.
  task automatic pick_settings();
    cfg_word_t   scale_val;
    cfg_word_t   width_val;
    int unsigned sel;
    sel = $urandom_range(0, 11);
    case (sel)
      0: begin
        scale_val = {6'($urandom), 5'd0};
      end
      1: begin
        scale_val = cfg_word_t'(MAX_SCALE);
      end
      2: begin
        scale_val = {6'($urandom), 5'($urandom_range(17, 31))};
      end
      default: begin
        scale_val = cfg_word_t'($urandom_range(1, 4));
      end
    endcase
    if (sb.scale_of(scale_val[4:0]) == MAX_SCALE) begin
      width_val = cfg_word_t'($urandom_range(1, 3));
    end else begin
      sel = $urandom_range(0, 9);
      if (sel == 0) width_val = '0;
      else if (sel == 1) width_val = cfg_word_t'($urandom_range(9, 40));
      else width_val = cfg_word_t'($urandom_range(1, 8));
    end
    if (!sb.width_is_safe(width_val)) width_val = cfg_word_t'(sb.filled);
    program_regs(scale_val, width_val);
  endtask

  initial begin
    sb            = new();
    tx_eager      = 1'b0;
    rx_eager      = 1'b0;
    long_hold_req = 1'b0;
    random_items  = 0;
    in_ch.valid   = 1'b0;
    in_ch.op      = pru_pkg::OP_PUSH;
    in_ch.blue    = '0;
    in_ch.green   = '0;
    in_ch.red     = '0;
    cfg_we        = 1'b0;
    cfg_addr      = pru_pkg::CFG_SCALE_FACTOR;
    cfg_data      = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Settings straight out of reset: scale one, width one. A tick with
    // nothing to replay must yield no word; each push is a whole row on its
    // own, with one byte of padding.
    send_item(pru_pkg::OP_TICK, 8'h00, 8'h00, 8'h00);
    send_item(pru_pkg::OP_PUSH, 8'h00, 8'h00, 8'h00);
    send_item(pru_pkg::OP_PUSH, 8'hFF, 8'hFF, 8'hFF);

    // Scale two over a three-pixel row: one replay row is armed, a push
    // during it is dropped, and a tick after it is idle again.
    program_regs(11'd2, 11'd3);
    send_item(pru_pkg::OP_PUSH, 8'hFF, 8'h00, 8'hFF);
    send_item(pru_pkg::OP_PUSH, 8'h00, 8'hFF, 8'h00);
    send_item(pru_pkg::OP_PUSH, 8'hA5, 8'h5A, 8'hC3);
    send_item(pru_pkg::OP_PUSH, 8'h3C, 8'hC3, 8'h5A);
    repeat (3) send_item(pru_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF);
    send_item(pru_pkg::OP_TICK, 8'h00, 8'h00, 8'h00);

    // A scale above the maximum saturates to sixteen and arms fifteen replay
    // rows. After one of them the scale drops to zero (acting as one) and the
    // width to zero (acting as one): the armed row count stays, only the
    // number of copies per tick changes.
    program_regs(11'd31, 11'd1);
    send_item(pru_pkg::OP_PUSH, 8'h5A, 8'hA5, 8'h3C);
    send_item(pru_pkg::OP_TICK, 8'h00, 8'h00, 8'h00);
    program_regs(11'd0, 11'd0);
    repeat (14) send_item(pru_pkg::OP_TICK, 8'h00, 8'h00, 8'h00);

    // A row that shrinks under the write index: after five pushes into a row
    // whose width is asked for beyond the maximum (with a scale of zero, so
    // one word per pixel), the width becomes three, so the next push lands on
    // the last position and ends the row there.
    program_regs(11'd0, 11'h7FF);
    repeat (5) send_item(pru_pkg::OP_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    program_regs(11'd1, 11'd3);
    send_item(pru_pkg::OP_PUSH, 8'($urandom), 8'($urandom), 8'($urandom));

    // Back-pressure: the output side stalls for a long stretch while the
    // input side offers words without gaps, so the block fills and holds off
    // its input.
    tx_eager = 1'b1;
    rx_eager = 1'b0;
    program_regs(cfg_word_t'(MAX_SCALE), 11'd3);
    long_hold_req = 1'b1;
    run_phase(NO_LIMIT);

    // Random phases, each with fresh settings and idling behaviour.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      pick_settings();
      run_phase(($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : NO_LIMIT);
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
